[hw/rtl/fpfp_pkg.sv]
// Shared types and constants of the float pixel format packer.
package fpfp_pkg;

    localparam int LANES           = 4;
    localparam int MAX_WIDTH       = 4096;
    localparam int ROW_ALIGN_BYTES = 256;

    typedef enum logic [1:0] {
        FMT_UNORM8  = 2'd0,
        FMT_UNORM16 = 2'd1,
        FMT_HALF    = 2'd2,
        FMT_RAW     = 2'd3
    } fmt_t;

    typedef enum logic [1:0] {
        CFG_ROW_WIDTH     = 2'd0,
        CFG_CHANNEL_COUNT = 2'd1,
        CFG_OUT_FORMAT    = 2'd2,
        CFG_NONE          = 2'd3
    } cfg_idx_t;

    localparam logic KIND_VALUE   = 1'b0;
    localparam logic KIND_PADDING = 1'b1;

    // Per-pixel control that travels beside the lane data.
    typedef struct packed {
        fmt_t       fmt;
        logic [2:0] cc;      // channels to emit, 1..4
        logic [7:0] pad;     // padding bytes
        logic       pad_en;  // pixel closes a row that needs padding
    } pix_meta_t;

    function automatic logic [7:0] bytes_per_chan(input fmt_t fmt);
        logic [7:0] b;
        unique case (fmt)
            FMT_UNORM8:  b = 8'd1;
            FMT_UNORM16: b = 8'd2;
            FMT_HALF:    b = 8'd2;
            FMT_RAW:     b = 8'd4;
            default:     b = 8'd1;
        endcase
        return b;
    endfunction

endpackage

[hw/rtl/float_pixel_format_packer.sv]
// Top level of the float pixel format packer: input stage, row tracking, lanes and merge.
//
// Usage:
//   Slave stream (s_*) takes one pixel per beat: four binary32 channels in tdata.
//   Master stream (m_*) gives one result per beat: a converted channel value
//   (tuser 0) or a row padding run (tuser 1); tlast marks the final beat of a pixel.
//   The config channel (cfg_*) writes row_width, channel_count and out_format;
//   it is always ready and should be used only while the block is idle.
// Path: a pixel passes the input register, three lane stages, the merge hold register and
//   the output register before m_tvalid rises for its first beat.
// Flow: the single result port of the merge stage issues a pixel's channel beats, then
//   a padding beat if the pixel closes a row needing padding; the next pixel enters as the
//   last beat issues. The four lanes convert all channels of a pixel together.
// Reset: clears all valid flags and the column count; registers return to row_width 1,
//   channel_count 4, unorm8.
// Stall: when m_tready is low the output beat holds and the merge stage holds its pixel;
//   while one is held the lane pipeline freezes and s_tready falls; nothing is lost or repeated.
module float_pixel_format_packer
    import fpfp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // chan_r[31:0], chan_g[63:32], chan_b[95:64], chan_a[127:96]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [39:0]  m_tdata,   // out_value[31:0], byte_len[39:32]
    output logic         m_tuser,   // item_kind
    output logic         m_tlast,   // last_of_pixel
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [12:0]  cfg_data
);

    logic [12:0] row_width_reg;
    logic [2:0]  chan_count_reg;
    fmt_t        fmt_reg;
    logic [11:0] col_reg, col_next;

    logic        s1_valid_reg, s2_valid_reg, s3_valid_reg;
    pix_meta_t   s1_meta_reg, s2_meta_reg, s3_meta_reg;
    pix_meta_t   meta_next;
    logic [31:0] chan_reg [LANES];
    logic [31:0] lane_value [LANES];

    logic        adv;
    logic        accept;
    logic [12:0] width;
    logic [2:0]  cc;
    logic [1:0]  bsh;
    logic [16:0] row_bytes;
    logic        row_end;

    assign cfg_ready = 1'b1;
    assign s_tready  = adv;
    assign accept    = s_tvalid && adv;

    always_comb
    begin
        if (row_width_reg == 13'd0)
            width = 13'd1;
        else if (row_width_reg > 13'(MAX_WIDTH))
            width = 13'(MAX_WIDTH);
        else
            width = row_width_reg;

        if (chan_count_reg == 3'd0)
            cc = 3'd1;
        else if (chan_count_reg > 3'(LANES))
            cc = 3'(LANES);
        else
            cc = chan_count_reg;

        unique case (fmt_reg)
            FMT_UNORM8:  bsh = 2'd0;
            FMT_UNORM16: bsh = 2'd1;
            FMT_HALF:    bsh = 2'd1;
            FMT_RAW:     bsh = 2'd2;
            default:     bsh = 2'd0;
        endcase

        row_end   = ({1'b0, col_reg} + 13'd1) >= width;
        row_bytes = 17'((17'(width) << bsh) * 17'(cc));
        col_next  = row_end ? 12'd0 : col_reg + 12'd1;

        meta_next.fmt    = fmt_reg;
        meta_next.cc     = cc;
        meta_next.pad_en = row_end && (row_bytes < 17'(ROW_ALIGN_BYTES));
        meta_next.pad    = 8'(9'(ROW_ALIGN_BYTES) - row_bytes[8:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg  <= 13'd1;
            chan_count_reg <= 3'd4;
            fmt_reg        <= FMT_UNORM8;
            col_reg        <= 12'd0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_ROW_WIDTH:     row_width_reg  <= cfg_data;
                    CFG_CHANNEL_COUNT: chan_count_reg <= cfg_data[2:0];
                    CFG_OUT_FORMAT:    fmt_reg        <= fmt_t'(cfg_data[1:0]);
                    CFG_NONE:          ;
                    default:           ;
                endcase
            end
            if (accept)
                col_reg <= col_next;
            if (adv)
            begin
                s1_valid_reg <= s_tvalid;
                s2_valid_reg <= s1_valid_reg;
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_meta_reg <= meta_next;
            s2_meta_reg <= s1_meta_reg;
            s3_meta_reg <= s2_meta_reg;
            for (int i = 0; i < LANES; i++)
                chan_reg[i] <= s_tdata[32*i +: 32];
        end
    end

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        fpfp_lane u_lane (
            .clk   (clk),
            .en    (adv),
            .bits  (chan_reg[g]),
            .fmt   (s1_meta_reg.fmt),
            .value (lane_value[g])
        );
    end

    fpfp_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s3_valid_reg),
        .in_meta    (s3_meta_reg),
        .lane_value (lane_value),
        .adv        (adv),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

[hw/rtl/fpfp_lane.sv]
// One conversion lane: binary32 channel to unorm8, unorm16, half or raw, three stages.
module fpfp_lane
    import fpfp_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] bits,
    input  fmt_t        fmt,
    output logic [31:0] value
);

    // stage A: product
    logic [39:0] prod_reg,  prod_next;
    logic [5:0]  sh_a_reg,  sh_a_next;
    logic        zero_a_reg, zero_a_next;
    logic        sat_a_reg,  sat_a_next;
    logic [31:0] bits_a_reg;
    fmt_t        fmt_a_reg;
    // stage B: rounded product
    logic [40:0] rnd_reg,   rnd_next;
    logic [5:0]  sh_b_reg;
    logic        zero_b_reg;
    logic        sat_b_reg;
    logic [31:0] bits_b_reg;
    fmt_t        fmt_b_reg;
    // stage C: result
    logic [31:0] value_reg, value_next;

    logic [7:0]  expo;
    logic [22:0] mant;
    logic        sgn;
    logic [15:0] k_a;
    logic [7:0]  sh_full;

    always_comb
    begin
        sgn  = bits[31];
        expo = bits[30:23];
        mant = bits[22:0];
        k_a  = (fmt == FMT_UNORM16) ? 16'hffff : 16'h00ff;
        prod_next = 40'({1'b1, mant}) * 40'(k_a);
        sh_full   = 8'd150 - expo;
        sh_a_next = sh_full[5:0];
        // zero: negative, NaN, subnormal or zero, or shifted out entirely
        zero_a_next = sgn || (expo == 8'hff && mant != 23'd0) || (expo == 8'd0)
                      || (expo <= 8'd90);
        sat_a_next  = (expo >= 8'd150);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg   <= prod_next;
            sh_a_reg   <= sh_a_next;
            zero_a_reg <= zero_a_next;
            sat_a_reg  <= sat_a_next;
            bits_a_reg <= bits;
            fmt_a_reg  <= fmt;
        end
    end

    logic        big16;
    logic        top;
    logic [4:0]  rs;
    logic [40:0] unit, mask, rem, half, base;
    logic        up;

    always_comb
    begin
        big16 = (fmt_a_reg == FMT_UNORM16);
        top   = big16 ? prod_reg[39] : prod_reg[31];
        // round to 24 significant bits: drop n or n-1 low bits
        if (big16)
            rs = top ? 5'd16 : 5'd15;
        else
            rs = top ? 5'd8 : 5'd7;
        unit = 41'd1 << rs;
        mask = unit - 41'd1;
        rem  = {1'b0, prod_reg} & mask;
        half = unit >> 1;
        base = {1'b0, prod_reg} & ~mask;
        up   = (rem > half) || (rem == half && (base & unit) != 41'd0);
        rnd_next = base + (up ? unit : 41'd0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rnd_reg    <= rnd_next;
            sh_b_reg   <= sh_a_reg;
            zero_b_reg <= zero_a_reg;
            sat_b_reg  <= sat_a_reg;
            bits_b_reg <= bits_a_reg;
            fmt_b_reg  <= fmt_a_reg;
        end
    end

    logic [40:0] shifted;
    logic [15:0] k_b;
    logic [15:0] unorm;
    logic [7:0]  hexp;
    logic [4:0]  e5;
    logic [15:0] half_val;

    always_comb
    begin
        k_b     = (fmt_b_reg == FMT_UNORM16) ? 16'hffff : 16'h00ff;
        shifted = rnd_reg >> sh_b_reg;
        if (zero_b_reg)
            unorm = 16'd0;
        else if (sat_b_reg || shifted > 41'(k_b))
            unorm = k_b;
        else
            unorm = shifted[15:0];
        hexp     = bits_b_reg[30:23];
        e5       = (hexp > 8'h70) ? hexp[4:0] - 5'h10 : 5'd0;
        half_val = {bits_b_reg[31], e5, bits_b_reg[22:13]};
        unique case (fmt_b_reg)
            FMT_UNORM8:  value_next = {16'd0, unorm};
            FMT_UNORM16: value_next = {16'd0, unorm};
            FMT_HALF:    value_next = {16'd0, half_val};
            FMT_RAW:     value_next = bits_b_reg;
            default:     value_next = bits_b_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
            value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

[hw/rtl/fpfp_merge.sv]
// Merge stage: holds one converted pixel and issues its result beats in order.
module fpfp_merge
    import fpfp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  pix_meta_t        in_meta,
    input  logic [31:0]      lane_value [LANES],
    output logic             adv,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [39:0]      m_tdata,
    output logic             m_tuser,
    output logic             m_tlast
);

    logic       hold_valid_reg, hold_valid_next;
    pix_meta_t  meta_reg;
    logic [2:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    logic [39:0] data_reg;
    logic       kind_reg;
    logic       last_reg;

    logic       out_load;
    logic       emit;
    logic [2:0] n_items;
    logic       is_last;
    logic       release_px;
    logic       beat_kind;
    logic [31:0] beat_value;
    logic [7:0] beat_len;

    always_comb
    begin
        out_load   = !out_valid_reg || m_tready;
        emit       = hold_valid_reg && out_load;
        n_items    = meta_reg.cc + {2'd0, meta_reg.pad_en};
        is_last    = (idx_reg == n_items - 3'd1);
        release_px = emit && is_last;
        adv        = !hold_valid_reg || release_px;

        if (idx_reg < meta_reg.cc)
        begin
            beat_kind  = KIND_VALUE;
            beat_value = lane_value[idx_reg[1:0]];
            beat_len   = bytes_per_chan(meta_reg.fmt);
        end
        else
        begin
            beat_kind  = KIND_PADDING;
            beat_value = 32'd0;
            beat_len   = meta_reg.pad;
        end

        if (adv)
        begin
            hold_valid_next = in_valid;
            idx_next        = 3'd0;
        end
        else
        begin
            hold_valid_next = hold_valid_reg;
            idx_next        = emit ? idx_reg + 3'd1 : idx_reg;
        end
        out_valid_next = out_load ? emit : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            idx_reg        <= 3'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            idx_reg        <= idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            meta_reg <= in_meta;
        if (emit)
        begin
            data_reg <= {beat_len, beat_value};
            kind_reg <= beat_kind;
            last_reg <= is_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

endmodule
